### hdl/saq_pkg.sv
// Package for the scanline alarm queue: sizes, opcodes, slot record and helpers.
package saq_pkg;

  localparam int ALARM_SLOTS = 16;
  localparam int LINES_PER_FRAME = 263;
  localparam int ID_W = $clog2(ALARM_SLOTS);
  localparam int LINK_W = ID_W + 1;
  localparam int LINE_W = 9;
  localparam int FRAME_W = 32;
  localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = {1'b1, {ID_W{1'b0}}};

  typedef enum logic [1:0] {
    OP_LINE = 2'd0,
    OP_ONESHOT = 2'd1,
    OP_PERIODIC = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  // One slot record as held in the slot memory.
  typedef struct packed {
    logic [FRAME_W-1:0] due_frame;
    logic [LINE_W-1:0] due_line;
    logic [LINE_W-1:0] limit;
    logic periodic;
    logic queued;
    logic [LINK_W-1:0] next;
  } slot_t;

  // Memory port command from the sequencer to the slot memory.
  typedef struct packed {
    logic we;
    logic [ID_W-1:0] waddr;
    slot_t wdata;
    logic [ID_W-1:0] raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic kind;
    logic [3:0] fired_id;
    logic fired;
    logic [LINE_W-1:0] late_lines;
    logic [LINE_W-1:0] next_line;
    logic irq_enable;
    logic last;
  } result_t;

  function automatic logic link_null(input logic [LINK_W-1:0] l);
    return l[LINK_W-1];
  endfunction

endpackage

### hdl/saq_if.sv
// Valid/ready channel interfaces for input words and result words.
interface saq_in_if import saq_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [3:0] alarm_id;
  logic [LINE_W-1:0] line;
  logic [LINE_W-1:0] target_line;
  logic [LINE_W-1:0] late_limit;
  modport source(output valid, opcode, alarm_id, line, target_line, late_limit,
                 input ready);
  modport sink(input valid, opcode, alarm_id, line, target_line, late_limit,
               output ready);
endinterface

interface saq_out_if import saq_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic kind;
  logic [3:0] fired_id;
  logic fired;
  logic [LINE_W-1:0] late_lines;
  logic [LINE_W-1:0] next_line;
  logic irq_enable;
  logic last;
  modport source(output valid, kind, fired_id, fired, late_lines, next_line, irq_enable,
                 last, input ready);
  modport sink(input valid, kind, fired_id, fired, late_lines, next_line, irq_enable, last,
               output ready);
endinterface

### hdl/scanline_alarm_queue.sv
// Top level of the scanline alarm queue: sequencer over the slot memory.
//
//   channel | dir | payload
//   in_ch   | in  | opcode, alarm_id, line, target_line, late_limit
//   out_ch  | out | kind, fired_id, fired, late_lines, next_line, irq_enable, last
//
// One word is worked at a time. A cancel reads the slot, unlinks it if it is queued
// and stores it as idle; an arm does the same unlink and then a sorted insert.
// An unlink walks the list entries and then patches the link, and a sorted insert
// walks the entries and patches a predecessor when there is one.
// A line event checks the head and dequeues the due alarms one by one; each
// dequeued periodic alarm is relinked with its insert walk.
// Reset is synchronous and marks every slot unqueued through the valid bits
// below, so no clearing pass is needed. Each result waits in the output
// register; the sequencer stalls only when it must push a new result while the
// register is still full.
module scanline_alarm_queue import saq_pkg::*; (
  input logic clk,
  input logic rst,
  saq_in_if.sink in_ch,
  saq_out_if.source out_ch
);
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_HRD    = 14'b00000000000010, // head read issued for dequeue check
    S_HCHK   = 14'b00000000000100,
    S_ULRD   = 14'b00000000001000, // read target slot for unlink
    S_ULCHK  = 14'b00000000010000,
    S_ULWALK = 14'b00000000100000, // walking predecessors
    S_ULFIX  = 14'b00000001000000,
    S_LKWALK = 14'b00000010000000, // sorted insert walk
    S_LKFIX  = 14'b00000100000000,
    S_LKNEW  = 14'b00001000000000,
    S_STRD   = 14'b00010000000000, // head read for status
    S_STOUT  = 14'b00100000000000,
    S_RPT    = 14'b01000000000000,
    S_LKRD   = 14'b10000000000000  // head read that starts a sorted insert
  } state_t;

  state_t state;
  logic [FRAME_W-1:0] frame_count;
  logic [LINE_W-1:0] last_line;
  logic [LINK_W-1:0] head_link;
  logic [ALARM_SLOTS-1:0] written;   // slot holds a written record
  logic [1:0] op;
  logic [ID_W-1:0] id;
  logic [LINE_W-1:0] line, target, limit;
  slot_t rec;                        // record being moved (unlinked or linked)
  logic [LINK_W-1:0] cur, prev;
  slot_t prev_rec;
  logic [CNT_W-1:0] steps;
  logic [CNT_W-1:0] count;
  logic rpt_pending;
  result_t rpt;

  mem_cmd_t cmd;
  slot_t rdata, rd;
  logic push, out_full;
  result_t push_data;

  saq_slot_mem u_mem (.clk(clk), .cmd(cmd), .rdata(rdata));
  saq_out_reg u_out (.clk(clk), .rst(rst), .push(push), .data(push_data),
                     .full(out_full), .o(out_ch));

  // Slots never written read as the reset record.
  logic [ID_W-1:0] rd_addr;
  always_ff @(posedge clk) begin
    rd_addr <= cmd.raddr;
  end
  always_comb begin
    rd = rdata;
    if (!written[rd_addr]) begin
      rd = '0;
      rd.next = NULL_LINK;
    end
  end

  assign in_ch.ready = (state == S_IDLE);

  logic [FRAME_W-1:0] samp_frame;
  assign samp_frame = (in_ch.line < last_line) ? frame_count + 1'b1 : frame_count;

  // rec goes before the slot just read when it sorts strictly earlier.
  logic ins_before;
  assign ins_before = (rec.due_frame < rd.due_frame) ||
                      ((rec.due_frame == rd.due_frame) && (rec.due_line < rd.due_line));

  always_comb begin
    cmd = '0;
    push = 1'b0;
    push_data = '0;
    unique case (state)
      S_IDLE, S_HRD, S_ULCHK, S_LKRD, S_STRD, S_STOUT: cmd.raddr = head_link[ID_W-1:0];
      S_ULRD: cmd.raddr = id;
      S_HCHK: cmd.raddr = rd.next[ID_W-1:0];
      S_ULWALK: cmd.raddr = rd.next[ID_W-1:0];
      S_LKWALK: cmd.raddr = rd.next[ID_W-1:0];
      default: cmd.raddr = cur[ID_W-1:0];
    endcase
    unique case (state)
      S_ULFIX: begin
        cmd.we = 1'b1;
        cmd.waddr = prev[ID_W-1:0];
        cmd.wdata = prev_rec;
        cmd.wdata.next = rec.next;
      end
      S_LKFIX: begin
        cmd.we = 1'b1;
        cmd.waddr = prev[ID_W-1:0];
        cmd.wdata = prev_rec;
        cmd.wdata.next = {1'b0, id};
      end
      S_LKNEW: begin
        cmd.we = 1'b1;
        cmd.waddr = id;
        cmd.wdata = rec;
        cmd.wdata.queued = 1'b1;
        cmd.wdata.next = cur;
      end
      S_RPT: begin
        // The dequeued alarm is stored as idle; a periodic one is relinked later.
        cmd.we = 1'b1;
        cmd.waddr = id;
        cmd.wdata = rec;
        push = !out_full;
        push_data = rpt;
      end
      S_STRD: begin
        // A cancelled alarm is stored as idle once it is off the list.
        if (op == OP_CANCEL) begin
          cmd.we = 1'b1;
          cmd.waddr = id;
          cmd.wdata = rec;
          cmd.wdata.queued = 1'b0;
          cmd.wdata.next = NULL_LINK;
        end
      end
      S_STOUT: begin
        push = !out_full;
        push_data.kind = 1'b1;
        push_data.last = 1'b1;
        push_data.irq_enable = !link_null(head_link);
        push_data.next_line = link_null(head_link) ? '0 : rd.due_line;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      frame_count <= '0;
      last_line <= '0;
      head_link <= NULL_LINK;
      written <= '0;
      count <= '0;
    end else begin
      if (cmd.we) begin
        written[cmd.waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op <= in_ch.opcode;
            id <= in_ch.alarm_id[ID_W-1:0];
            line <= in_ch.line;
            target <= in_ch.target_line;
            limit <= in_ch.late_limit;
            count <= '0;
            if (in_ch.opcode != OP_CANCEL) begin
              frame_count <= samp_frame;
              last_line <= in_ch.line;
            end
            if (in_ch.opcode == OP_LINE) begin
              state <= S_HCHK;
            end else begin
              state <= S_ULRD;
            end
          end
        end
        S_HRD: state <= S_HCHK;
        S_HCHK: begin
          if (link_null(head_link) || count == CNT_W'(ALARM_SLOTS) ||
              frame_count < rd.due_frame || line < rd.due_line) begin
            state <= S_STRD;
          end else begin
            count <= count + 1'b1;
            head_link <= rd.next;
            id <= head_link[ID_W-1:0];
            rpt.kind <= 1'b0;
            rpt.fired_id <= 4'(head_link[ID_W-1:0]);
            rpt.fired <= (line - rd.due_line) <= rd.limit;
            rpt.late_lines <= line - rd.due_line;
            rpt.next_line <= '0;
            rpt.irq_enable <= 1'b0;
            rpt.last <= 1'b0;
            rec <= rd;
            rec.queued <= 1'b0;
            rec.next <= NULL_LINK;
            rec.due_frame <= frame_count + 1'b1;
            rpt_pending <= rd.periodic;
            state <= S_RPT;
          end
        end
        S_RPT: begin
          if (!out_full) begin
            // A periodic alarm is requeued from the head as it is now.
            state <= rpt_pending ? S_LKRD : S_HRD;
          end
        end
        S_ULRD: state <= S_ULCHK;
        S_ULCHK: begin
          rec <= rd;
          cur <= head_link;
          if (op != OP_CANCEL) begin
            rec.due_line <= target;
            rec.limit <= limit;
            rec.periodic <= (op == OP_PERIODIC);
            rec.due_frame <= (target > line) ? frame_count : frame_count + 1'b1;
          end
          if (!rd.queued) begin
            state <= (op == OP_CANCEL) ? S_STRD : S_LKRD;
          end else if (head_link == {1'b0, id}) begin
            head_link <= rd.next;
            state <= (op == OP_CANCEL) ? S_STRD : S_LKRD;
          end else begin
            state <= S_ULWALK;
          end
        end
        S_ULWALK: begin
          // rd is the record of cur; the first pass uses the head read from S_ULCHK.
          if (rd.next == {1'b0, id}) begin
            prev <= cur;
            prev_rec <= rd;
            state <= S_ULFIX;
          end else if (link_null(rd.next)) begin
            state <= (op == OP_CANCEL) ? S_STRD : S_LKRD;
          end else begin
            cur <= rd.next;
          end
        end
        S_ULFIX: state <= (op == OP_CANCEL) ? S_STRD : S_LKRD;
        S_LKRD: begin
          cur <= head_link;
          prev <= NULL_LINK;
          steps <= '0;
          state <= link_null(head_link) ? S_LKNEW : S_LKWALK;
        end
        S_LKWALK: begin
          if (ins_before || steps == CNT_W'(ALARM_SLOTS)) begin
            state <= link_null(prev) ? S_LKNEW : S_LKFIX;
          end else begin
            prev <= cur;
            prev_rec <= rd;
            cur <= rd.next;
            steps <= steps + 1'b1;
            if (link_null(rd.next)) begin
              state <= S_LKFIX;
            end
          end
        end
        S_LKFIX: state <= S_LKNEW;
        S_LKNEW: begin
          if (link_null(prev)) begin
            head_link <= {1'b0, id};
          end
          state <= (op == OP_LINE) ? S_HRD : S_STRD;
        end
        S_STRD: state <= S_STOUT;
        S_STOUT: if (!out_full) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/saq_slot_mem.sv
// Slot memory: one write port and one registered read port.
module saq_slot_mem import saq_pkg::*; (
  input  logic clk,
  input  mem_cmd_t cmd,
  output slot_t rdata
);
  slot_t mem [ALARM_SLOTS];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rdata <= mem[cmd.raddr];
  end
endmodule

### hdl/saq_out_reg.sv
// Output register that holds one result word until the sink takes it.
module saq_out_reg import saq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  result_t data,
  output logic full,
  saq_out_if.source o
);
  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (o.ready) begin
      full <= 1'b0;
    end
    if (push) begin
      held <= data;
    end
  end

  assign o.valid = full;
  assign o.kind = held.kind;
  assign o.fired_id = held.fired_id;
  assign o.fired = held.fired;
  assign o.late_lines = held.late_lines;
  assign o.next_line = held.next_line;
  assign o.irq_enable = held.irq_enable;
  assign o.last = held.last;
endmodule

### hdl/saq_checker.sv
// Port checker for the scanline alarm queue, bound to the top level.
module saq_checker import saq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kind,
  input logic out_last,
  input logic out_irq,
  input logic [LINE_W-1:0] out_next
);
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second word taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result word dropped");
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_last == out_kind) else $error("last and kind disagree");
  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_kind |-> !out_irq && out_next == '0) else $error("report has status");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind && !out_irq |-> out_next == '0) else $error("empty queue line");
endmodule

bind scanline_alarm_queue saq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.kind),
  .out_last(out_ch.last), .out_irq(out_ch.irq_enable), .out_next(out_ch.next_line)
);
